// ----- hdl/double_ended_queue_with_search_assert.svh -----
// ---------------------------------------------------------------------------
// Deque assertion macros
// Shared concurrent assertion forms for the deque; they expect clk and rst
// in scope and are disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_ASSERT_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define DEQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed: implication violated");

// The condition must never be true.
`define DEQ_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("deque check failed: forbidden condition seen");

`endif

// ----- hdl/deq_pkg.sv -----
// ---------------------------------------------------------------------------
// Deque package
// Field widths, operation and status codes, and the request, response and
// internal command types shared by the deque modules.
// ---------------------------------------------------------------------------
package deq_pkg;

  // Default number of ring entries.
  localparam int CAPACITY_DEF = 16;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes carried by a request.
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_DROP_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_DROP_BACK  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

  // Status codes carried by a response.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [COUNT_W-1:0]  element_count;
  } rsp_t;

  // Decoded command handed from the front end to the execution side.
  // All flags low means an unused operation code.
  typedef struct packed {
    logic                      push;
    logic                      drop;
    logic                      at_front;
    logic                      query;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

// ----- hdl/deq_ram.sv -----
// ---------------------------------------------------------------------------
// Deque RAM
// Generic single write port, single read port memory with registered read
// data.
// ---------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/deq_front.sv -----
// ---------------------------------------------------------------------------
// Deque front end
// Accepts requests, decodes the operation code into command flags and holds
// the command in one register stage until the command queue takes it.
// ---------------------------------------------------------------------------
module deq_front import deq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_full,
  output cmd_t cmd
);

  logic stg_valid;
  cmd_t cmd_dec;
  logic accept;

  // Decode the operation; unused codes leave every flag low.
  always_comb begin
    cmd_dec          = '0;
    cmd_dec.value    = req.value;
    case (req.operation)
      OP_PUSH_BACK: begin
        cmd_dec.push = 1'b1;
      end
      OP_PUSH_FRONT: begin
        cmd_dec.push     = 1'b1;
        cmd_dec.at_front = 1'b1;
      end
      OP_DROP_FRONT: begin
        cmd_dec.drop     = 1'b1;
        cmd_dec.at_front = 1'b1;
      end
      OP_DROP_BACK: begin
        cmd_dec.drop = 1'b1;
      end
      OP_QUERY: begin
        cmd_dec.query = 1'b1;
      end
      default: begin
        cmd_dec.push = 1'b0;
      end
    endcase
  end

  // The stage stalls only while it holds a command the queue cannot take.
  assign req_stall = stg_valid && cmd_full;
  assign accept    = req_valid && !req_stall;
  assign cmd_valid = stg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (!cmd_full) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_dec;
    end
  end

endmodule

// ----- hdl/deq_cmdq.sv -----
// ---------------------------------------------------------------------------
// Deque command queue
// Two-entry queue that decouples the front end from the execution side.
// ---------------------------------------------------------------------------
module deq_cmdq import deq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic full,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push_en;
  logic       pop_en;

  assign full      = (fill == 2'd2);
  assign pop_valid = (fill != 2'd0);
  assign pop_cmd   = slots[rd_ptr];
  assign push_en   = push_valid && !full;
  assign pop_en    = pop && pop_valid;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push_en && !pop_en) begin
        fill <= fill + 2'd1;
      end else if (pop_en && !push_en) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_en) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- hdl/deq_back.sv -----
// ---------------------------------------------------------------------------
// Deque execution side
// Keeps the ring state, carries out pushes and drops without a scan, scans the
// ring one entry per cycle for a membership query and registers the response.
// ---------------------------------------------------------------------------
module deq_back import deq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                      state;
  logic [IDX_W-1:0]          front_index;
  logic [CNT_W-1:0]          held_count;
  logic [IDX_W-1:0]          ptr;
  logic [CNT_W-1:0]          issued;
  logic                      last;
  logic signed [VALUE_W-1:0] qvalue;

  logic [IDX_W-1:0]          front_index_next;
  logic [CNT_W-1:0]          held_count_next;
  logic [STATUS_W-1:0]       status_d;
  logic                      out_free;
  logic                      start;
  logic                      is_full;
  logic                      is_empty;
  logic [SUM_W-1:0]          back_sum;
  logic [SUM_W-1:0]          back_wrap;
  logic                      we;
  logic [IDX_W-1:0]          waddr;
  logic [IDX_W-1:0]          raddr;
  logic [VALUE_W-1:0]        rdata;
  logic                      hit;
  logic                      scan_done;
  logic                      rsp_set;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(CAPACITY - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? IDX_W'(CAPACITY - 1) : idx - IDX_W'(1);
  endfunction

  // A new command starts when idle and the response register is free.
  assign out_free = !rsp_valid || !rsp_stall;
  assign start    = (state == S_IDLE) && cmd_valid && out_free;
  assign cmd_pop  = start;
  assign is_full  = (held_count == CNT_W'(CAPACITY));
  assign is_empty = (held_count == '0);

  // Slot behind the back element: front plus count, wrapped once.
  assign back_sum  = SUM_W'(front_index) + SUM_W'(held_count);
  assign back_wrap = (back_sum >= SUM_W'(CAPACITY)) ? back_sum - SUM_W'(CAPACITY)
                                                    : back_sum;

  // Next ring state and status for a push or drop.
  always_comb begin
    front_index_next = front_index;
    held_count_next  = held_count;
    status_d         = ST_DONE;
    if (cmd.push) begin
      if (is_full) begin
        status_d = ST_FULL;
      end else begin
        held_count_next = held_count + CNT_W'(1);
        if (cmd.at_front) begin
          front_index_next = ring_dec(front_index);
        end
      end
    end else if (cmd.drop) begin
      if (is_empty) begin
        status_d = ST_EMPTY;
      end else begin
        held_count_next = held_count - CNT_W'(1);
        if (cmd.at_front) begin
          front_index_next = ring_inc(front_index);
        end
      end
    end
  end

  // Store access: pushes write, the scan reads the front first, then ptr.
  assign we    = start && cmd.push && !is_full;
  assign waddr = cmd.at_front ? ring_dec(front_index) : back_wrap[IDX_W-1:0];
  assign raddr = (state == S_IDLE) ? front_index : ptr;

  deq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cmd.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Compare the entry read in the previous cycle.
  assign hit       = (rdata == qvalue);
  assign scan_done = hit || last;

  // A response is loaded by a command that needs no scan or by the end of a scan.
  assign rsp_set = (start && !(cmd.query && !is_empty)) ||
                   ((state == S_SCAN) && scan_done);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front_index <= '0;
      held_count  <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      rsp_valid <= rsp_set || (rsp_valid && rsp_stall);
      case (state)
        S_IDLE: begin
          if (start) begin
            front_index <= front_index_next;
            held_count  <= held_count_next;
            if (cmd.query && !is_empty) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Scan bookkeeping and response payload.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      if (start) begin
        rsp.status        <= status_d;
        rsp.found         <= 1'b0;
        rsp.element_count <= COUNT_W'(held_count_next);
        ptr               <= ring_inc(front_index);
        issued            <= CNT_W'(1);
        last              <= (held_count == CNT_W'(1));
        qvalue            <= cmd.value;
      end
    end else if (scan_done) begin
      rsp.status        <= ST_DONE;
      rsp.found         <= hit;
      rsp.element_count <= COUNT_W'(held_count);
    end else begin
      ptr    <= ring_inc(ptr);
      issued <= issued + CNT_W'(1);
      last   <= ((issued + CNT_W'(1)) == held_count);
    end
  end

endmodule

// ----- hdl/double_ended_queue_with_search.sv -----
// ---------------------------------------------------------------------------
// Double-ended queue with search
// Path: decode stage register, command queue, response register; a query first scans the held entries.
// Throughput: one per cycle unless stalled; a query scans one entry a cycle and holds later commands until it ends.
// Reset clears the front index and the count; the store itself is not cleared.
// ---------------------------------------------------------------------------
`include "double_ended_queue_with_search_assert.svh"

module double_ended_queue_with_search import deq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic stg_valid;
  logic cq_full;
  cmd_t stg_cmd;
  logic cq_valid;
  cmd_t cq_cmd;
  logic cq_pop;

  // Request decode stage.
  deq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_valid (stg_valid),
    .cmd_full  (cq_full),
    .cmd       (stg_cmd)
  );

  // Command queue between decode and execution.
  deq_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (stg_valid),
    .push_cmd   (stg_cmd),
    .full       (cq_full),
    .pop_valid  (cq_valid),
    .pop_cmd    (cq_cmd),
    .pop        (cq_pop)
  );

  // Ring state, store and response register.
  deq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cq_valid),
    .cmd       (cq_cmd),
    .cmd_pop   (cq_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // A hit is only ever reported with a done status.
  `DEQ_ASSERT_IMPL(a_found_done, rsp_valid && rsp.found, rsp.status == ST_DONE)
  // A rejected push reports a full store.
  `DEQ_ASSERT_IMPL(a_full_count, rsp_valid && (rsp.status == ST_FULL),
                   rsp.element_count == COUNT_W'(CAPACITY))
  // A rejected drop reports an empty store.
  `DEQ_ASSERT_NEVER(a_empty_count,
                    rsp_valid && (rsp.status == ST_EMPTY) && (rsp.element_count != '0))

endmodule

// ----- test/deq_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Deque response checker
// Watches the request and response channels of the deque, keeps its own
// ring-store model of the queue contents, predicts the response for every
// accepted request and compares each accepted response field by field.
// ---------------------------------------------------------------------------
module deq_checker import deq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   mismatch_count,
  output int   outstanding
);

  // Model of the deque: ring entries, index of the front element, element count.
  logic signed [VALUE_W-1:0] ring_entries [CAPACITY];
  int unsigned               front_slot;
  int unsigned               held;

  // Responses predicted for accepted requests, oldest first.
  rsp_t expected_rsps [$];
  rsp_t oldest;
  int   errors = 0;

  // Apply one request to the model and return the response it should produce.
  function automatic rsp_t deque_apply(input req_t r);
    rsp_t res;
    res        = '0;
    res.status = ST_DONE;
    case (r.operation)
      OP_PUSH_BACK: begin
        if (held >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          ring_entries[(front_slot + held) % CAPACITY] = r.value;
          held++;
        end
      end
      OP_PUSH_FRONT: begin
        if (held >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          front_slot               = (front_slot + CAPACITY - 1) % CAPACITY;
          ring_entries[front_slot] = r.value;
          held++;
        end
      end
      OP_DROP_FRONT: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          front_slot = (front_slot + 1) % CAPACITY;
          held--;
        end
      end
      OP_DROP_BACK: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          held--;
        end
      end
      OP_QUERY: begin
        // Only held entries are searched, so unwritten slots are never read.
        for (int i = 0; i < held; i++) begin
          if (ring_entries[(front_slot + i) % CAPACITY] == r.value) begin
            res.found = 1'b1;
          end
        end
      end
      default: begin
        // Unused codes leave the queue untouched.
      end
    endcase
    res.element_count = COUNT_W'(held);
    return res;
  endfunction

  // Responses are checked before the request of the same edge is modeled;
  // a response can never belong to a request accepted at that same edge.
  always @(posedge clk) begin
    if (rst) begin
      front_slot = 0;
      held       = 0;
      expected_rsps.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: response with no request waiting, actual %p", $time, rsp);
          errors++;
        end else begin
          oldest = expected_rsps.pop_front();
          if (rsp.status !== oldest.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, oldest.status, rsp.status);
            errors++;
          end
          if (rsp.found !== oldest.found) begin
            $display("%0t: found mismatch, expected %0d, actual %0d",
                     $time, oldest.found, rsp.found);
            errors++;
          end
          if (rsp.element_count !== oldest.element_count) begin
            $display("%0t: element_count mismatch, expected %0d, actual %0d",
                     $time, oldest.element_count, rsp.element_count);
            errors++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(deque_apply(req));
      end
    end
    outstanding    <= expected_rsps.size();
    mismatch_count <= errors;
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Deque testbench
// Drives directed and random push, drop and search requests into the deque
// with bursty request traffic and a randomly stalling response side, and
// gives the verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
module tb_top;
  import deq_pkg::*;

  localparam int CAPACITY        = CAPACITY_DEF;
  localparam int RANDOM_REQUESTS = 1850;
  localparam int MODE_SPAN       = 48;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES   = 2 * CAPACITY + 8;
  localparam int CYCLE_LIMIT     = 600000;

  // First and last of the operation codes that the deque does not use.
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

  // Traffic mix used by the random part; each keeps the count drifting.
  typedef enum int {FILL_UP, DRAIN_DOWN, MIXED, SEARCH_HEAVY} traffic_mode_e;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  int mismatch_count;
  int outstanding;
  int cycle_count = 0;

  // Recently pushed values, reused so that searches hit held elements.
  logic signed [VALUE_W-1:0] value_pool [8];

  double_ended_queue_with_search #(.CAPACITY(CAPACITY)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  deq_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop in case the deque hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Present one request and hold it until the deque takes it.
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [VALUE_W-1:0] value);
    req_valid     <= 1'b1;
    req.operation <= op;
    req.value     <= value;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Build one random request for the given traffic mix.
  function automatic req_t next_request(input traffic_mode_e mode);
    req_t r;
    int   push_pct;
    int   drop_pct;
    int   roll;
    int   pick;
    case (mode)
      FILL_UP: begin
        push_pct = 70;
        drop_pct = 15;
      end
      DRAIN_DOWN: begin
        push_pct = 20;
        drop_pct = 65;
      end
      MIXED: begin
        push_pct = 45;
        drop_pct = 40;
      end
      default: begin
        push_pct = 25;
        drop_pct = 20;
      end
    endcase

    // Value: extremes now and then, often a recent value, otherwise fresh.
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0:       r.value = VALUE_MIN;
        1:       r.value = VALUE_MAX;
        2:       r.value = '0;
        default: r.value = '1;
      endcase
    end else if (pick <= 4) begin
      r.value = value_pool[$urandom_range(0, 7)];
    end else begin
      r.value = $urandom();
    end

    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      r.operation = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        r.operation = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        value_pool[$urandom_range(0, 7)] = r.value;
      end else if (roll < push_pct + drop_pct) begin
        r.operation = $urandom_range(0, 1) ? OP_DROP_FRONT : OP_DROP_BACK;
      end else begin
        r.operation = OP_QUERY;
      end
    end
    return r;
  endfunction

  // Response side: stretches of free flow, random stalling and long hold-offs.
  initial begin : response_pacing
    int segment;
    int span;
    int stall_pct;
    rsp_stall <= 1'b0;
    segment = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (segment == 6 || $urandom_range(0, 24) == 0) begin
        // Long hold-off so the deque backs up and stalls requests.
        rsp_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        span = $urandom_range(8, 60);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
        repeat (span) begin
          rsp_stall <= ($urandom_range(0, 99) < stall_pct);
          @(posedge clk);
        end
      end
      segment++;
    end
  end

  // Request side: reset, directed requests, random bursts, then the verdict.
  initial begin : request_stimulus
    int                        sent;
    int                        burst;
    int                        gap;
    traffic_mode_e             mode;
    logic signed [VALUE_W-1:0] last_value;
    req_t                      item;

    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    foreach (value_pool[k]) value_pool[k] = $urandom();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Operations on an empty deque, including an unused code.
    send_request(OP_QUERY, '0);
    send_request(OP_DROP_FRONT, '0);
    send_request(OP_DROP_BACK, '1);
    send_request(OP_SPARE_LAST, VALUE_MAX);

    // Dropping the only element from either end empties the deque.
    send_request(OP_PUSH_BACK, VALUE_MAX);
    send_request(OP_DROP_BACK, '0);
    send_request(OP_PUSH_FRONT, VALUE_MIN);
    send_request(OP_DROP_FRONT, '0);

    // Fill to capacity from both ends, extremes among the values.
    send_request(OP_PUSH_BACK, '0);
    send_request(OP_PUSH_FRONT, '1);
    send_request(OP_PUSH_BACK, VALUE_MAX);
    send_request(OP_PUSH_FRONT, VALUE_MIN);
    last_value = '0;
    for (int k = 0; k < CAPACITY - 4; k++) begin
      last_value = $urandom();
      send_request(k[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, last_value);
    end

    // Full deque: rejected pushes, searches over every entry, unused code.
    send_request(OP_PUSH_BACK, '1);
    send_request(OP_PUSH_FRONT, '0);
    send_request(OP_QUERY, last_value);
    send_request(OP_QUERY, VALUE_MIN);
    send_request(OP_QUERY, 32'sh1234_5678);
    send_request(OP_SPARE_FIRST, '0);

    // Random bursts with gaps; the traffic mix changes every few dozen requests.
    sent = 0;
    mode = MIXED;
    while (sent < RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (sent % MODE_SPAN == 0) begin
          mode = traffic_mode_e'($urandom_range(0, 3));
        end
        item = next_request(mode);
        send_request(item.operation, item.value);
        sent++;
      end
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_valid <= 1'b0;

    // Wait for every predicted response, then let any stray one show up.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
